>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the RTL of the tokenizer.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge, held off while reset is low.
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks a property at every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> rtl/core/xta_pkg.sv
// ----------------------------------------------------------------------------
// XML tag tokenizer package
// Types, character codes and limits shared by the tokenizer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package xta_pkg;

  // Field widths of one item and one result.
  localparam int DATA_W  = 8;
  localparam int IDX_W   = 4;
  localparam int POS_W   = 10;

  // Attribute slots and token length limits (each limit counts a terminator).
  localparam int ATTR_SLOTS      = 10;
  localparam int TAG_NAME_LIMIT  = 256;
  localparam int ATTR_NAME_LIMIT = 256;
  localparam int VALUE_LIMIT     = 1024;

  localparam logic [IDX_W-1:0] SLOTS_FULL   = IDX_W'(ATTR_SLOTS);
  localparam logic [POS_W-1:0] TAG_LONG_AT  = POS_W'(TAG_NAME_LIMIT - 1);
  localparam logic [POS_W-1:0] NAME_LONG_AT = POS_W'(ATTR_NAME_LIMIT - 1);
  localparam logic [POS_W-1:0] VAL_LONG_AT  = POS_W'(VALUE_LIMIT - 1);
  localparam logic [POS_W-1:0] POS_MAX      = '1;

  // Characters that steer the parser.
  localparam logic [DATA_W-1:0] CH_LT    = 8'h3C;
  localparam logic [DATA_W-1:0] CH_GT    = 8'h3E;
  localparam logic [DATA_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [DATA_W-1:0] CH_EQ    = 8'h3D;
  localparam logic [DATA_W-1:0] CH_QUOTE = 8'h22;
  localparam logic [DATA_W-1:0] CH_SPACE = 8'h20;

  // Parser phase.
  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_LT        = 4'd1,
    PH_TAG       = 4'd2,
    PH_GAP       = 4'd3,
    PH_ANAME     = 4'd4,
    PH_QUOTE     = 4'd5,
    PH_VALUE     = 4'd6,
    PH_SKIPOPEN  = 4'd7,
    PH_SKIPCLOSE = 4'd8,
    PH_XNAME     = 4'd9,
    PH_XQUOTE    = 4'd10,
    PH_XVALUE    = 4'd11
  } xta_phase_e;

  // Event code of a result.
  typedef enum logic [2:0] {
    EV_NONE         = 3'd0,
    EV_TAG_CHAR     = 3'd1,
    EV_ANAME_CHAR   = 3'd2,
    EV_VALUE_CHAR   = 3'd3,
    EV_OPEN_DONE    = 3'd4,
    EV_CLOSE_DONE   = 3'd5,
    EV_UNTERMINATED = 3'd6
  } xta_event_e;

  // Parser state carried from one item to the next.
  typedef struct packed {
    xta_phase_e       phase;
    logic [IDX_W-1:0] attr_counter;
    logic [POS_W-1:0] token_position;
    logic             token_started;
  } xta_state_t;

  // One result item.
  typedef struct packed {
    xta_event_e        event_res;
    logic [DATA_W-1:0] char_out;
    logic [IDX_W-1:0]  attr_index;
    logic [POS_W-1:0]  position;
    logic              first_char;
    logic [IDX_W-1:0]  attr_total;
    logic              too_long;
    logic              too_many_attrs;
  } xta_res_t;

  localparam xta_state_t STATE_RESET = '{
    phase:          PH_IDLE,
    attr_counter:   '0,
    token_position: '0,
    token_started:  1'b0
  };

endpackage

`default_nettype wire

>>> rtl/core/xta_in_if.sv
// ----------------------------------------------------------------------------
// Tokenizer input channel
// Valid/ready channel that carries one text byte and its last marker.
// ----------------------------------------------------------------------------
`default_nettype none

interface xta_in_if;
  import xta_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_byte;
  logic              last;

  modport source (output valid, output data_byte, output last, input ready);
  modport sink   (input valid, input data_byte, input last, output ready);

endinterface

`default_nettype wire

>>> rtl/core/xta_out_if.sv
// ----------------------------------------------------------------------------
// Tokenizer output channel
// Valid/ready channel that carries one labelled byte.
// ----------------------------------------------------------------------------
`default_nettype none

interface xta_out_if;
  import xta_pkg::*;

  logic              valid;
  logic              ready;
  logic [2:0]        event_res;
  logic [DATA_W-1:0] char_out;
  logic [IDX_W-1:0]  attr_index;
  logic [POS_W-1:0]  position;
  logic              first_char;
  logic [IDX_W-1:0]  attr_total;
  logic              too_long;
  logic              too_many_attrs;

  modport source (
    output valid, output event_res, output char_out, output attr_index,
    output position, output first_char, output attr_total, output too_long,
    output too_many_attrs, input ready
  );
  modport sink (
    input valid, input event_res, input char_out, input attr_index,
    input position, input first_char, input attr_total, input too_long,
    input too_many_attrs, output ready
  );

endinterface

`default_nettype wire

>>> rtl/core/xta_step.sv
// ----------------------------------------------------------------------------
// Tokenizer step logic
// Combinational next state and result for one text byte.
// ----------------------------------------------------------------------------
`default_nettype none

module xta_step (
  input  xta_pkg::xta_state_t          state_i,
  input  logic [xta_pkg::DATA_W-1:0]   data_byte_i,
  input  logic                         last_i,
  output xta_pkg::xta_state_t          state_o,
  output xta_pkg::xta_res_t            res_o
);
  import xta_pkg::*;

  logic             fresh;
  logic [POS_W-1:0] lbl_pos;
  logic [POS_W-1:0] lbl_next_pos;
  logic             slots_full;
  logic [IDX_W-1:0] cur_slot;

  // A token starts afresh after '<' or a gap, or when nothing is running.
  assign fresh = !state_i.token_started || (state_i.phase == PH_LT) ||
                 (state_i.phase == PH_GAP);
  assign lbl_pos = fresh ? '0 : state_i.token_position;
  assign lbl_next_pos = fresh ? POS_W'(1) :
                        (state_i.token_position < POS_MAX) ?
                        POS_W'(state_i.token_position + POS_W'(1)) :
                        state_i.token_position;

  assign slots_full = state_i.attr_counter >= SLOTS_FULL;
  assign cur_slot   = IDX_W'(state_i.attr_counter - IDX_W'(1));

  // Phase decoding, labelling and the final-byte check.
  always_comb begin
    state_o                = state_i;
    res_o.event_res        = EV_NONE;
    res_o.char_out         = data_byte_i;
    res_o.attr_index       = '0;
    res_o.position         = '0;
    res_o.first_char       = 1'b0;
    res_o.attr_total       = '0;
    res_o.too_long         = 1'b0;
    res_o.too_many_attrs   = 1'b0;

    unique case (state_i.phase)
      PH_LT, PH_TAG: begin
        if ((state_i.phase == PH_LT) && (data_byte_i == CH_SLASH)) begin
          state_o.phase = PH_SKIPCLOSE;
        end else begin
          if (state_i.phase == PH_LT) begin
            state_o.phase         = PH_TAG;
            state_o.token_started = 1'b0;
          end
          if (data_byte_i == CH_SPACE) begin
            state_o.phase = PH_GAP;
          end else if (data_byte_i == CH_GT) begin
            res_o.event_res        = EV_OPEN_DONE;
            res_o.attr_total       = state_i.attr_counter;
            state_o                = STATE_RESET;
          end else if (data_byte_i == CH_SLASH) begin
            state_o.phase = PH_SKIPOPEN;
          end else begin
            res_o.event_res        = EV_TAG_CHAR;
            res_o.position         = lbl_pos;
            res_o.first_char       = fresh;
            res_o.too_long         = lbl_pos >= TAG_LONG_AT;
            state_o.token_started  = 1'b1;
            state_o.token_position = lbl_next_pos;
          end
        end
      end
      PH_GAP: begin
        if (data_byte_i == CH_SPACE) begin
          state_o.phase = PH_GAP;
        end else if (data_byte_i == CH_GT) begin
          res_o.event_res  = EV_OPEN_DONE;
          res_o.attr_total = state_i.attr_counter;
          state_o          = STATE_RESET;
        end else if (data_byte_i == CH_SLASH) begin
          state_o.phase = PH_SKIPOPEN;
        end else if (data_byte_i == CH_EQ) begin
          // An attribute with an empty name.
          if (slots_full) begin
            res_o.too_many_attrs = 1'b1;
            state_o.phase        = PH_XQUOTE;
          end else begin
            state_o.attr_counter = IDX_W'(state_i.attr_counter + IDX_W'(1));
            state_o.phase        = PH_QUOTE;
          end
        end else if (slots_full) begin
          res_o.too_many_attrs = 1'b1;
          state_o.phase        = PH_XNAME;
        end else begin
          state_o.attr_counter   = IDX_W'(state_i.attr_counter + IDX_W'(1));
          state_o.phase          = PH_ANAME;
          res_o.event_res        = EV_ANAME_CHAR;
          res_o.attr_index       = state_i.attr_counter;
          res_o.position         = lbl_pos;
          res_o.first_char       = fresh;
          res_o.too_long         = lbl_pos >= NAME_LONG_AT;
          state_o.token_started  = 1'b1;
          state_o.token_position = lbl_next_pos;
        end
      end
      PH_ANAME: begin
        if (data_byte_i == CH_EQ) begin
          state_o.phase = PH_QUOTE;
        end else if (data_byte_i == CH_GT) begin
          res_o.event_res  = EV_OPEN_DONE;
          res_o.attr_total = state_i.attr_counter;
          state_o          = STATE_RESET;
        end else begin
          res_o.event_res        = EV_ANAME_CHAR;
          res_o.attr_index       = cur_slot;
          res_o.position         = lbl_pos;
          res_o.first_char       = fresh;
          res_o.too_long         = lbl_pos >= NAME_LONG_AT;
          state_o.token_started  = 1'b1;
          state_o.token_position = lbl_next_pos;
        end
      end
      PH_QUOTE: begin
        // The opening quote is skipped whatever it is.
        state_o.phase         = PH_VALUE;
        state_o.token_started = 1'b0;
      end
      PH_VALUE: begin
        if (data_byte_i == CH_QUOTE) begin
          state_o.phase = PH_GAP;
        end else begin
          res_o.event_res        = EV_VALUE_CHAR;
          res_o.attr_index       = cur_slot;
          res_o.position         = lbl_pos;
          res_o.first_char       = fresh;
          res_o.too_long         = lbl_pos >= VAL_LONG_AT;
          state_o.token_started  = 1'b1;
          state_o.token_position = lbl_next_pos;
        end
      end
      PH_XNAME: begin
        if (data_byte_i == CH_GT) begin
          res_o.event_res  = EV_OPEN_DONE;
          res_o.attr_total = state_i.attr_counter;
          state_o          = STATE_RESET;
        end else begin
          res_o.too_many_attrs = 1'b1;
          if (data_byte_i == CH_EQ) begin
            state_o.phase = PH_XQUOTE;
          end
        end
      end
      PH_XQUOTE: begin
        res_o.too_many_attrs = 1'b1;
        state_o.phase        = PH_XVALUE;
      end
      PH_XVALUE: begin
        res_o.too_many_attrs = 1'b1;
        if (data_byte_i == CH_QUOTE) begin
          state_o.phase = PH_GAP;
        end
      end
      PH_SKIPOPEN: begin
        if (data_byte_i == CH_GT) begin
          res_o.event_res  = EV_OPEN_DONE;
          res_o.attr_total = state_i.attr_counter;
          state_o          = STATE_RESET;
        end
      end
      PH_SKIPCLOSE: begin
        if (data_byte_i == CH_GT) begin
          res_o.event_res = EV_CLOSE_DONE;
          state_o.phase   = PH_IDLE;
        end
      end
      default: begin
        // Idle, and any unused phase code behaves as idle.
        if (data_byte_i == CH_LT) begin
          state_o.phase          = PH_LT;
          state_o.attr_counter   = '0;
          state_o.token_started  = 1'b0;
          state_o.token_position = '0;
        end else begin
          state_o.phase = PH_IDLE;
        end
      end
    endcase

    // The final byte closes the stream; an open tag is reported.
    if (last_i) begin
      if (state_o.phase != PH_IDLE) begin
        res_o.event_res      = EV_UNTERMINATED;
        res_o.attr_index     = '0;
        res_o.position       = '0;
        res_o.first_char     = 1'b0;
        res_o.attr_total     = '0;
        res_o.too_long       = 1'b0;
        res_o.too_many_attrs = 1'b0;
      end
      state_o = STATE_RESET;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/xml_tag_attribute_tokenizer_top.sv
// ----------------------------------------------------------------------------
// XML tag and attribute tokenizer
// The result of each accepted byte is registered in the output register.
// Throughput: one byte per cycle; the parser state updates on every accepted byte.
// A byte is taken while the output register is empty or being read out.
// Reset (asynchronous, active low) sets the parser to idle outside any tag and
// empties the output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module xml_tag_attribute_tokenizer_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  xta_in_if.sink    in_i,
  xta_out_if.source out_o
);
  import xta_pkg::*;

  xta_state_t state_q;
  xta_state_t state_d;
  xta_res_t   res_q;
  xta_res_t   res_d;
  logic       out_valid_q;
  logic       in_acc;
  logic       last_acc;
  logic       parser_idle;
  logic       total_stray;

  // A new item enters whenever the result register is free or draining.
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_acc     = in_i.valid && in_i.ready;

  xta_step u_step (
    .state_i     (state_q),
    .data_byte_i (in_i.data_byte),
    .last_i      (in_i.last),
    .state_o     (state_d),
    .res_o       (res_d)
  );

  // Parser state register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= STATE_RESET;
    end else if (in_acc) begin
      state_q <= state_d;
    end
  end

  // Output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.event_res      = res_q.event_res;
  assign out_o.char_out       = res_q.char_out;
  assign out_o.attr_index     = res_q.attr_index;
  assign out_o.position       = res_q.position;
  assign out_o.first_char     = res_q.first_char;
  assign out_o.attr_total     = res_q.attr_total;
  assign out_o.too_long       = res_q.too_long;
  assign out_o.too_many_attrs = res_q.too_many_attrs;

  // Terms used by the assertions.
  assign last_acc    = in_acc && in_i.last;
  assign parser_idle = (state_q.phase == PH_IDLE) && (state_q.attr_counter == '0) &&
                       !state_q.token_started;
  assign total_stray = (res_q.event_res != EV_OPEN_DONE) && (res_q.attr_total != '0);

  // Assertions.
  `ASSERT_RST(a_slots_bound, clk_i, rst_ni, state_q.attr_counter <= SLOTS_FULL, "slot overrun")
  `ASSERT_RST(a_last_resets, clk_i, rst_ni, last_acc |=> parser_idle, "busy after last byte")
  `ASSERT_RST(a_total_only_open, clk_i, rst_ni, out_valid_q |-> !total_stray, "stray total")
  `ASSERT_RST(a_ready_when_empty, clk_i, rst_ni, !out_valid_q |-> in_i.ready, "stalled empty")

endmodule

`default_nettype wire
